/* hw/rtl/animation_frame_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the animation frame sequencer
// Short forms for clocked checks with an overlapping or a next-cycle consequent.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define ANIMATION_FRAME_SEQUENCER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define AFSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("afsu port check failed");

// Consequent must hold in the cycle after the antecedent
`define AFSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("afsu port check failed");

`endif

/* hw/rtl/afsu_pkg.sv */
// ----------------------------------------------------------------------------
// afsu_pkg
// Shared types and constants of the animation frame sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afsu_pkg;

    // Command codes of an input transaction
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_TOGGLE   = 3'd1,
        CMD_PREV     = 3'd2,
        CMD_NEXT     = 3'd3,
        CMD_RESTART  = 3'd4,
        CMD_START    = 3'd5,
        CMD_LOAD     = 3'd6,
        CMD_SET_MODE = 3'd7
    } t_cmd;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PAUSE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_COUNT     = 2'd2;

    // Timing constants
    localparam logic [11:0] TICK_MS        = 12'd100;
    localparam logic [10:0] INTERVAL_MIN   = 11'd100;
    localparam logic [10:0] INTERVAL_MAX   = 11'd2000;
    localparam logic [10:0] INTERVAL_RESET = 11'd200;
    localparam logic [9:0]  PAUSE_MAX      = 10'd600;
    localparam logic [9:0]  MS_PER_SECOND  = 10'd1000;

    // Files beyond this are never played, whatever the count register says
    localparam int LIVE_LIMIT = 256;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input transaction payload
    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] file_index;
        logic [15:0] frame_total;
        logic        mode_value;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        logic        render_request;
        logic [7:0]  render_file;
        logic [15:0] render_frame;
        logic        mode_now;
        logic        pausing;
        logic        inactive;
    } t_out_item;

    // Classified operation handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic        load_en;
        logic [15:0] file_index;
        logic [15:0] frame_total;
        logic        mode_value;
    } t_op;

endpackage

`default_nettype wire

/* hw/rtl/animation_frame_sequencer_unit.sv */
// Path: a transaction accepted into the queue is executed and its result registered
//   (queue entry, execute with table read, result register).
// Flow: the back end takes a new operation only once the last result is registered,
//   set by the execute/complete pair around the frame-table read port in the back end.
// Reset: synchronous, active low; clears playback state, queue and the per-entry
//   valid bits of the frame table, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// animation_frame_sequencer_unit
// Plays multi-frame animation files on a 100 ms tick, with file stepping and modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module animation_frame_sequencer_unit
    import afsu_pkg::*;
#(
    parameter int MAX_FILES = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    localparam int TBL_DEPTH = (MAX_FILES < LIVE_LIMIT) ? MAX_FILES : LIVE_LIMIT;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    logic              op_valid;
    t_op               op;
    logic              op_pop;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [15:0]       tbl_wdata;
    logic [TBL_AW-1:0] tbl_raddr;
    logic [15:0]       tbl_rdata;

    // Accept and classify
    afsu_front #(
        .MAX_FILES (MAX_FILES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_pop   (op_pop)
    );

    // Execute
    afsu_back #(
        .MAX_FILES (MAX_FILES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_pop    (op_pop),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Per-file frame count table
    afsu_ram #(
        .WIDTH (16),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/afsu_ram.sv */
// ----------------------------------------------------------------------------
// afsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/afsu_front.sv */
// ----------------------------------------------------------------------------
// afsu_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afsu_front
    import afsu_pkg::*;
#(
    parameter int MAX_FILES = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_op_valid,
    output t_op           o_op,
    input  wire logic     i_op_pop
);

    localparam int TBL_DEPTH = (MAX_FILES < LIVE_LIMIT) ? MAX_FILES : LIVE_LIMIT;

    t_op               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_op               cls_op;
    logic              push;
    logic              pop;

    // Classify the incoming command; table entries that are never read are dropped here
    always_comb begin
        cls_op.cmd         = t_cmd'(i_in_data.command);
        cls_op.load_en     = (cls_op.cmd == CMD_LOAD) &&
                             ({1'b0, i_in_data.file_index} < 17'(TBL_DEPTH));
        cls_op.file_index  = i_in_data.file_index;
        cls_op.frame_total = i_in_data.frame_total;
        cls_op.mode_value  = i_in_data.mode_value;
    end

    assign o_in_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_op_pop && o_op_valid;
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_op;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afsu_back.sv */
// ----------------------------------------------------------------------------
// afsu_back
// Executes queued operations: playback state, frame table, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afsu_back
    import afsu_pkg::*;
#(
    parameter int MAX_FILES = 256,
    localparam int TBL_DEPTH = (MAX_FILES < LIVE_LIMIT) ? MAX_FILES : LIVE_LIMIT,
    localparam int TBL_AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_op_valid,
    input  wire t_op                   i_op,
    output logic                       o_op_pop,
    output logic                       o_tbl_we,
    output logic [TBL_AW-1:0]          o_tbl_waddr,
    output logic [15:0]                o_tbl_wdata,
    output logic [TBL_AW-1:0]          o_tbl_raddr,
    input  wire logic [15:0]           i_tbl_rdata,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    typedef enum logic {
        ST_EXEC,
        ST_DONE
    } t_state;

    t_state         r_state;
    logic [10:0]    r_interval;
    logic [9:0]     r_pause;
    logic [8:0]     r_live;
    logic           r_mode;
    logic [7:0]     r_cur_file;
    logic [15:0]    r_cur_frames;
    logic [15:0]    r_frame_idx;
    logic [11:0]    r_accum;
    logic [19:0]    r_wait;
    logic           r_start_pend;
    logic           r_rendered;
    logic           r_rd_vld;
    logic           r_tbl_vld [TBL_DEPTH];

    logic           n_mode;
    logic [7:0]     n_cur_file;
    logic [15:0]    n_frame_idx;
    logic [11:0]    n_accum;
    logic [19:0]    n_wait;
    logic           n_start_pend;
    logic           n_rendered;

    logic [8:0]     cur_eff;
    logic [9:0]     fwd_sum;
    logic [9:0]     bwd_sum;
    logic [8:0]     fwd_tgt;
    logic [8:0]     bwd_tgt;
    logic [8:0]     idx_tgt;
    logic [8:0]     start_tgt;
    logic           do_start;
    logic           play_on;
    logic [11:0]    acc_sum;
    logic [16:0]    idx_inc;
    logic [19:0]    pause_ms;
    logic [15:0]    frames_new;
    logic           exec_go;
    logic           done_go;
    logic [10:0]    cfg_interval;
    logic [9:0]     cfg_pause;
    logic [8:0]     cfg_live;

    assign exec_go  = (r_state == ST_EXEC) && i_op_valid;
    assign done_go  = (r_state == ST_DONE) && (!o_out_valid || i_out_ready);
    assign o_op_pop = exec_go;

    // File step targets: out-of-range current file counts from file 0
    always_comb begin
        cur_eff = ({1'b0, r_cur_file} >= r_live) ? 9'd0 : {1'b0, r_cur_file};
        fwd_sum = {1'b0, cur_eff} + 10'd1;
        bwd_sum = {1'b0, cur_eff} + {1'b0, r_live} - 10'd1;
        fwd_tgt = (fwd_sum >= {1'b0, r_live}) ? 9'(fwd_sum - {1'b0, r_live}) : fwd_sum[8:0];
        bwd_tgt = (bwd_sum >= {1'b0, r_live}) ? 9'(bwd_sum - {1'b0, r_live}) : bwd_sum[8:0];
        idx_tgt = ({1'b0, i_op.file_index} >= {8'd0, r_live}) ? 9'd0 : i_op.file_index[8:0];
    end

    // Tick arithmetic
    assign play_on  = (r_live != 9'd0) && (r_cur_frames != 16'd0);
    assign acc_sum  = r_accum + TICK_MS;
    assign idx_inc  = {1'b0, r_frame_idx} + 17'd1;
    assign pause_ms = 20'(r_pause) * 20'(MS_PER_SECOND);

    // Execute one operation
    always_comb begin
        n_mode       = r_mode;
        n_cur_file   = r_cur_file;
        n_frame_idx  = r_frame_idx;
        n_accum      = r_accum;
        n_wait       = r_wait;
        n_rendered   = 1'b0;
        do_start     = 1'b0;
        start_tgt    = 9'd0;

        unique case (i_op.cmd)
            CMD_TICK: begin
                if (play_on) begin
                    if (r_wait != 20'd0) begin
                        if (r_wait > 20'(TICK_MS)) begin
                            n_wait = r_wait - 20'(TICK_MS);
                        end else begin
                            // pause over: new round
                            n_wait  = 20'd0;
                            n_accum = 12'd0;
                            if (r_mode) begin
                                do_start  = 1'b1;
                                start_tgt = fwd_tgt;
                            end else begin
                                n_frame_idx = 16'd0;
                                n_rendered  = 1'b1;
                            end
                        end
                    end else if (acc_sum < {1'b0, r_interval}) begin
                        n_accum = acc_sum;
                    end else begin
                        n_accum = acc_sum - {1'b0, r_interval};
                        if (idx_inc < {1'b0, r_cur_frames}) begin
                            n_frame_idx = idx_inc[15:0];
                            n_rendered  = 1'b1;
                        end else if (r_cur_frames <= 16'd1 && !r_mode) begin
                            // one-frame file in single mode: hold
                            n_accum = acc_sum - {1'b0, r_interval};
                        end else if (r_pause != 10'd0) begin
                            n_wait = pause_ms;
                        end else begin
                            n_wait  = 20'd0;
                            n_accum = 12'd0;
                            if (r_mode) begin
                                do_start  = 1'b1;
                                start_tgt = fwd_tgt;
                            end else begin
                                n_frame_idx = 16'd0;
                                n_rendered  = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_TOGGLE: begin
                n_mode  = ~r_mode;
                n_accum = 12'd0;
                n_wait  = 20'd0;
            end
            CMD_PREV: begin
                do_start  = (r_live != 9'd0);
                start_tgt = bwd_tgt;
            end
            CMD_NEXT: begin
                do_start  = (r_live != 9'd0);
                start_tgt = fwd_tgt;
            end
            CMD_RESTART: begin
                do_start  = (r_live != 9'd0);
                start_tgt = 9'd0;
            end
            CMD_START: begin
                do_start  = (r_live != 9'd0);
                start_tgt = idx_tgt;
            end
            CMD_LOAD: begin
                n_rendered = 1'b0;
            end
            CMD_SET_MODE: begin
                n_mode  = i_op.mode_value;
                n_accum = 12'd0;
                n_wait  = 20'd0;
            end
            default: begin
                n_rendered = 1'b0;
            end
        endcase

        // Start a file: frame count arrives from the table next cycle
        n_start_pend = do_start;
        if (do_start) begin
            n_cur_file  = start_tgt[7:0];
            n_frame_idx = 16'd0;
            n_accum     = 12'd0;
            n_wait      = 20'd0;
            n_rendered  = 1'b1;
        end
    end

    // Table ports; hold the read on the started file while the result waits
    assign o_tbl_we    = exec_go && i_op.load_en;
    assign o_tbl_waddr = i_op.file_index[TBL_AW-1:0];
    assign o_tbl_wdata = i_op.frame_total;
    assign o_tbl_raddr = (r_state == ST_DONE) ? r_cur_file[TBL_AW-1:0]
                                              : start_tgt[TBL_AW-1:0];

    // Entries never loaded read as zero
    assign frames_new = r_start_pend ? (r_rd_vld ? i_tbl_rdata : 16'd0) : r_cur_frames;

    // Configuration clamping
    always_comb begin
        cfg_interval = i_cfg_data[10:0];
        if (cfg_interval < INTERVAL_MIN) begin
            cfg_interval = INTERVAL_MIN;
        end else if (cfg_interval > INTERVAL_MAX) begin
            cfg_interval = INTERVAL_MAX;
        end
        cfg_pause = (i_cfg_data[9:0] > PAUSE_MAX) ? PAUSE_MAX : i_cfg_data[9:0];
        cfg_live  = (i_cfg_data[8:0] > 9'(TBL_DEPTH)) ? 9'(TBL_DEPTH) : i_cfg_data[8:0];
    end

    // State, playback registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_EXEC;
            r_interval   <= INTERVAL_RESET;
            r_pause      <= 10'd0;
            r_live       <= 9'd0;
            r_mode       <= 1'b0;
            r_cur_file   <= 8'd0;
            r_cur_frames <= 16'd0;
            r_frame_idx  <= 16'd0;
            r_accum      <= 12'd0;
            r_wait       <= 20'd0;
            r_start_pend <= 1'b0;
            r_rendered   <= 1'b0;
            r_rd_vld     <= 1'b0;
            o_out_valid  <= 1'b0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_tbl_vld[i] <= 1'b0;
            end
        end else begin
            r_rd_vld <= r_tbl_vld[o_tbl_raddr];
            if (o_tbl_we) begin
                r_tbl_vld[o_tbl_waddr] <= 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_EXEC: begin
                    if (exec_go) begin
                        r_mode       <= n_mode;
                        r_cur_file   <= n_cur_file;
                        r_frame_idx  <= n_frame_idx;
                        r_accum      <= n_accum;
                        r_wait       <= n_wait;
                        r_start_pend <= n_start_pend;
                        r_rendered   <= n_rendered;
                        r_state      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (done_go) begin
                        r_cur_frames               <= frames_new;
                        r_start_pend               <= 1'b0;
                        o_out_valid                <= 1'b1;
                        o_out_data.render_request  <= r_rendered;
                        o_out_data.render_file     <= r_cur_file;
                        o_out_data.render_frame    <= r_frame_idx;
                        o_out_data.mode_now        <= r_mode;
                        o_out_data.pausing         <= (r_wait != 20'd0);
                        o_out_data.inactive        <= (r_live == 9'd0) || (frames_new == 16'd0);
                        r_state                    <= ST_EXEC;
                    end
                end
                default: begin
                    r_state <= ST_EXEC;
                end
            endcase

            // Configuration writes must arrive only while idle; the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_INTERVAL: begin
                        r_interval <= cfg_interval;
                        r_accum    <= 12'd0;
                    end
                    CFG_LOOP_PAUSE: begin
                        r_pause <= cfg_pause;
                    end
                    CFG_FILE_COUNT: begin
                        r_live <= cfg_live;
                    end
                    default: begin
                        r_live <= r_live;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afsu_checker.sv */
// ----------------------------------------------------------------------------
// afsu_checker
// Port-level checks on the result channel of the animation frame sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "animation_frame_sequencer_unit_assert.svh"

module afsu_checker
    import afsu_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // Hold a stalled result
    `AFSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // A frame is never requested while the round pause runs
    `AFSU_ASSERT_SAME(a_no_render_in_pause, i_clk, i_rst_n, o_out_valid && o_out_data.pausing, !o_out_data.render_request)

    // Drop any result on reset
    `AFSU_ASSERT_NEXT(a_reset_drops_out, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind animation_frame_sequencer_unit afsu_checker u_afsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
